### hw/rtl/bsfp_pkg.sv
// ============================================================================
// bsfp_pkg
// Shared types and codes for the buffered serial FIFO pair.
// ============================================================================
package bsfp_pkg;

    // Event codes carried in the action field.
    localparam logic [2:0] ACT_HOST_WRITE = 3'd0;
    localparam logic [2:0] ACT_HOST_READ  = 3'd1;
    localparam logic [2:0] ACT_FLUSH      = 3'd2;
    localparam logic [2:0] ACT_RX_BYTE    = 3'd3;
    localparam logic [2:0] ACT_TX_READY   = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_REFUSED     = 2'd1;
    localparam logic [1:0] ST_EMPTY       = 2'd2;
    localparam logic [1:0] ST_DROPPED     = 2'd3;

    // One input transaction.
    typedef struct packed {
        logic [2:0] action;
        logic [7:0] data_in;
        logic       line_overrun;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic [7:0] data_out;
        logic [1:0] status;
        logic [7:0] rx_head;
        logic [6:0] rx_count;
        logic [6:0] tx_count;
        logic       error_flag;
        logic       tx_pending;
    } t_out_item;

    // Per-cycle commands from the sequencer to one ring buffer.
    typedef struct packed {
        logic rd_en;
        logic push;
        logic pop;
        logic flush;
    } t_ring_ctrl;

    // Sequencer states.
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

endpackage

### hw/rtl/bsfp_ring.sv
// ============================================================================
// bsfp_ring
// Ring buffer of bytes in a synchronous memory with pointers and fill count.
// ============================================================================
module bsfp_ring #(
    parameter int DEPTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bsfp_pkg::t_ring_ctrl           i_ctrl,
    input  logic                           i_look_ahead,
    input  logic [7:0]                     i_data,
    output logic [7:0]                     o_rdata,
    output logic [$clog2(DEPTH+1)-1:0]     o_fill,
    output logic                           o_empty,
    output logic                           o_full
);
    import bsfp_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [7:0]    mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_fill;
    logic [7:0]    r_rdata;
    logic [AW-1:0] wr_inc;
    logic [AW-1:0] rd_inc;
    logic [AW-1:0] rd_addr;

    // Pointer increments with wrap at the configured depth.
    assign wr_inc  = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign rd_inc  = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
    assign rd_addr = i_look_ahead ? rd_inc : r_rd;

    // Memory port: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            mem[r_wr] <= i_data;
        end
        if (i_ctrl.rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.flush) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_ctrl.push) begin
                r_wr <= wr_inc;
            end
            if (i_ctrl.pop) begin
                r_rd <= rd_inc;
            end
            if (i_ctrl.push && !i_ctrl.pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_ctrl.pop && !i_ctrl.push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    assign o_rdata = r_rdata;
    assign o_fill  = r_fill;
    assign o_empty = (r_fill == '0);
    assign o_full  = (r_fill == CW'(DEPTH));

endmodule

### hw/rtl/buffered_serial_fifo_pair.sv
// ============================================================================
// buffered_serial_fifo_pair
// Receive and transmit byte FIFOs between a serial line and a host.
// ============================================================================
// Usage:
//   The input channel (i_in_valid / o_in_ready / i_in_item) takes one event
//   per transaction: host write, host read, flush, received byte or
//   transmitter ready. Each event yields exactly one result transaction on
//   the output channel (o_out_valid / i_out_ready / o_out_item) with the
//   popped byte, a status code, the receive head byte, both fill counts,
//   the error flag and transmit-pending.
//   On acceptance the ring memories are read at the current pointers; the
//   update step then changes them from the registered read data and
//   registers the result, which raises result valid. The block takes no
//   new event until the update step of the last one is done.
//   The output register holds a finished result while the receiver stalls;
//   the next event is still accepted, and its update step waits until the
//   output register is free.
//   Synchronous reset empties both FIFOs and clears the error flag; the
//   ring memories are not cleared and need no clearing pass.
// ============================================================================
module buffered_serial_fifo_pair #(
    parameter int RX_DEPTH = 64,
    parameter int TX_DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  bsfp_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bsfp_pkg::t_out_item  o_out_item
);
    import bsfp_pkg::*;

    localparam int RCW = $clog2(RX_DEPTH + 1);
    localparam int TCW = $clog2(TX_DEPTH + 1);

    t_state     r_state;
    t_state     n_state;
    t_in_item   r_item;
    logic [7:0] r_head;
    logic [7:0] n_head;
    logic       r_overrun;
    logic       n_overrun;
    logic       r_out_valid;
    t_out_item  r_out_item;
    t_out_item  n_out_item;

    t_ring_ctrl     rx_ctrl;
    t_ring_ctrl     tx_ctrl;
    logic [7:0]     rx_rdata;
    logic [7:0]     tx_rdata;
    logic [RCW-1:0] rx_fill;
    logic [TCW-1:0] tx_fill;
    logic [RCW-1:0] rx_fill_new;
    logic [TCW-1:0] tx_fill_new;
    logic           rx_empty;
    logic           rx_full;
    logic           tx_empty;
    logic           tx_full;

    logic accept;
    logic fire;

    // Receive ring reads one slot ahead to fetch the next head after a pop.
    bsfp_ring #(
        .DEPTH (RX_DEPTH)
    ) u_rx_ring (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (rx_ctrl),
        .i_look_ahead (1'b1),
        .i_data       (r_item.data_in),
        .o_rdata      (rx_rdata),
        .o_fill       (rx_fill),
        .o_empty      (rx_empty),
        .o_full       (rx_full)
    );

    // Transmit ring reads the oldest slot.
    bsfp_ring #(
        .DEPTH (TX_DEPTH)
    ) u_tx_ring (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (tx_ctrl),
        .i_look_ahead (1'b0),
        .i_data       (r_item.data_in),
        .o_rdata      (tx_rdata),
        .o_fill       (tx_fill),
        .o_empty      (tx_empty),
        .o_full       (tx_full)
    );

    assign accept     = i_in_valid && o_in_ready;
    assign fire       = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_state == S_IDLE);

    // Sequencer: next state, ring commands and the result.
    always_comb begin
        n_state            = r_state;
        rx_ctrl            = '0;
        tx_ctrl            = '0;
        rx_ctrl.rd_en      = accept;
        tx_ctrl.rd_en      = accept;
        n_head             = r_head;
        n_overrun          = r_overrun;
        n_out_item         = '0;
        n_out_item.status  = ST_OK;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        unique case (r_item.action)
            ACT_HOST_WRITE: begin
                if (tx_full) begin
                    n_out_item.status = ST_REFUSED;
                end else begin
                    tx_ctrl.push = fire;
                end
            end
            ACT_HOST_READ: begin
                if (rx_empty) begin
                    n_out_item.status = ST_EMPTY;
                end else begin
                    rx_ctrl.pop         = fire;
                    n_out_item.data_out = r_head;
                    n_head              = rx_rdata;
                end
            end
            ACT_FLUSH: begin
                rx_ctrl.flush = fire;
                tx_ctrl.flush = fire;
                n_overrun     = 1'b0;
            end
            ACT_RX_BYTE: begin
                n_overrun = r_item.line_overrun;
                if (rx_full) begin
                    n_out_item.status = ST_DROPPED;
                end else begin
                    rx_ctrl.push = fire;
                    if (rx_empty) begin
                        n_head = r_item.data_in;
                    end
                end
            end
            ACT_TX_READY: begin
                if (tx_empty) begin
                    n_out_item.status = ST_EMPTY;
                end else begin
                    tx_ctrl.pop         = fire;
                    n_out_item.data_out = tx_rdata;
                end
            end
            default: begin
            end
        endcase

        // Fill counts as they stand after this event.
        if (rx_ctrl.flush) begin
            rx_fill_new = '0;
        end else if (rx_ctrl.push) begin
            rx_fill_new = rx_fill + 1'b1;
        end else if (rx_ctrl.pop) begin
            rx_fill_new = rx_fill - 1'b1;
        end else begin
            rx_fill_new = rx_fill;
        end
        if (tx_ctrl.flush) begin
            tx_fill_new = '0;
        end else if (tx_ctrl.push) begin
            tx_fill_new = tx_fill + 1'b1;
        end else if (tx_ctrl.pop) begin
            tx_fill_new = tx_fill - 1'b1;
        end else begin
            tx_fill_new = tx_fill;
        end

        n_out_item.rx_head    = (rx_fill_new != '0) ? n_head : 8'd0;
        n_out_item.rx_count   = 7'(rx_fill_new);
        n_out_item.tx_count   = 7'(tx_fill_new);
        n_out_item.error_flag = n_overrun;
        n_out_item.tx_pending = (tx_fill_new != '0);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_overrun   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fire) begin
                r_overrun   <= n_overrun;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_item;
        end
        if (fire) begin
            r_head     <= n_head;
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTH
    // A fill count never passes the ring depth.
    a_rx_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_fill <= RCW'(RX_DEPTH))
        else $error("receive fill count exceeds depth");

    a_tx_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tx_fill <= TCW'(TX_DEPTH))
        else $error("transmit fill count exceeds depth");

    // No ring is popped while it is empty.
    a_no_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rx_ctrl.pop && rx_empty) && !(tx_ctrl.pop && tx_empty))
        else $error("pop issued on an empty ring");

    // An accepted transaction blocks the input until its update step.
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("input accepted twice without an update step");
`endif

endmodule

### tb/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for the buffered serial FIFO pair. Events go in on a
// valid/ready channel and an event-level predictor of both ring FIFOs works
// out the result of each one. Every result transaction is compared field by
// field against the oldest prediction. Both channels idle and stall at
// random. Directed events cover the empty, full and flush cases; random
// traffic with varying push/pop bias covers the rest.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bsfp_pkg::*;

    localparam int RX_DEPTH = 64;
    localparam int TX_DEPTH = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 10;

    // Event codes above transmitter ready carry no meaning for the block.
    localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    // Per-side switches for random idle cycles.
    bit send_idle_on = 1'b1;
    bit recv_idle_on = 1'b1;

    int mismatch_count = 0;

    // Predictor state: both ring FIFOs and the line error flag.
    logic [7:0] rx_bytes [RX_DEPTH];
    logic [7:0] tx_bytes [TX_DEPTH];
    logic [5:0] rx_put = '0;
    logic [6:0] rx_held = '0;
    logic [5:0] tx_put = '0;
    logic [6:0] tx_held = '0;
    logic       overrun_latched = 1'b0;

    t_out_item expected_results [$];

    buffered_serial_fifo_pair #(
        .RX_DEPTH(RX_DEPTH),
        .TX_DEPTH(TX_DEPTH)
    ) uut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_in_item(in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item(out_item)
    );

    // Clock generation.
    initial begin
        forever #2 clk = ~clk;
    end

    // Slot of the oldest entry in a ring, given its write position and fill.
    function automatic int oldest_slot(int put, int held, int depth);
        return (put + depth - held) % depth;
    endfunction

    // Apply one event to the predicted FIFO state and return its result.
    function automatic t_out_item predict_fifo_event(t_in_item ev);
        t_out_item r;
        r = '0;
        case (ev.action)
            ACT_HOST_WRITE: begin
                if (tx_held >= TX_DEPTH) begin
                    r.status = ST_REFUSED;
                end else begin
                    tx_bytes[tx_put] = ev.data_in;
                    tx_put = (tx_put == TX_DEPTH - 1) ? '0 : tx_put + 1'b1;
                    tx_held++;
                end
            end
            ACT_HOST_READ: begin
                if (rx_held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data_out = rx_bytes[oldest_slot(rx_put, rx_held, RX_DEPTH)];
                    rx_held--;
                end
            end
            ACT_FLUSH: begin
                overrun_latched = 1'b0;
                rx_put = '0;
                rx_held = '0;
                tx_put = '0;
                tx_held = '0;
            end
            ACT_RX_BYTE: begin
                // The error flag follows the line even when the byte is dropped.
                overrun_latched = ev.line_overrun;
                if (rx_held >= RX_DEPTH) begin
                    r.status = ST_DROPPED;
                end else begin
                    rx_bytes[rx_put] = ev.data_in;
                    rx_put = (rx_put == RX_DEPTH - 1) ? '0 : rx_put + 1'b1;
                    rx_held++;
                end
            end
            ACT_TX_READY: begin
                if (tx_held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data_out = tx_bytes[oldest_slot(tx_put, tx_held, TX_DEPTH)];
                    tx_held--;
                end
            end
            default: begin
            end
        endcase
        if (rx_held != 0) begin
            r.rx_head = rx_bytes[oldest_slot(rx_put, rx_held, RX_DEPTH)];
        end
        r.rx_count = rx_held;
        r.tx_count = tx_held;
        r.error_flag = overrun_latched;
        r.tx_pending = (tx_held != 0);
        return r;
    endfunction

    function automatic t_in_item make_event(logic [2:0] action, logic [7:0] data,
                                            logic ovr);
        t_in_item ev;
        ev.action = action;
        ev.data_in = data;
        ev.line_overrun = ovr;
        return ev;
    endfunction

    // Random event; push_pct biases toward pushes into either FIFO.
    function automatic t_in_item random_event(int push_pct);
        int pick;
        logic [2:0] action;
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            action = ACT_FLUSH;
        end else if (pick < 5) begin
            action = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
        end else if ($urandom_range(0, 99) < push_pct) begin
            action = $urandom_range(0, 1) ? ACT_HOST_WRITE : ACT_RX_BYTE;
        end else begin
            action = $urandom_range(0, 1) ? ACT_HOST_READ : ACT_TX_READY;
        end
        return make_event(action, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endfunction

    task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("time %0t: %s mismatch, expected %0h, actual %0h",
                     $time, field, want, got);
        end
    endtask

    // Scoreboard: check each result transaction, then predict each new event.
    // A result always belongs to an event accepted at an earlier edge.
    always @(posedge clk) begin : scoreboard
        t_out_item want;
        if (out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                $display("time %0t: result mismatch, expected none, actual %p",
                         $time, out_item);
            end else begin
                want = expected_results.pop_front();
                check_field("data_out", want.data_out, out_item.data_out);
                check_field("status", want.status, out_item.status);
                check_field("rx_head", want.rx_head, out_item.rx_head);
                check_field("rx_count", want.rx_count, out_item.rx_count);
                check_field("tx_count", want.tx_count, out_item.tx_count);
                check_field("error_flag", want.error_flag, out_item.error_flag);
                check_field("tx_pending", want.tx_pending, out_item.tx_pending);
            end
        end
        if (in_valid && in_ready) begin
            expected_results.push_back(predict_fifo_event(in_item));
        end
    end

    // Result receiver: may hold ready low for a random gap before each transaction.
    initial begin : result_sink
        int gap;
        @(posedge rst_n);
        forever begin
            gap = recv_idle_on ? $urandom_range(0, 16) : 0;
            if (gap != 0) begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("testbench failed");
        $finish;
    end

    // Send one event; valid stays high from the previous one when there is no gap.
    task automatic send_event(t_in_item ev);
        int gap;
        gap = send_idle_on ? $urandom_range(0, 16) : 0;
        if (gap != 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item <= ev;
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    // Stop sending and wait for every outstanding result.
    task automatic hold_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    // Pops, unused codes and the flag on an empty block right after reset.
    task automatic test_empty_and_unused();
        send_event(make_event(ACT_HOST_READ, 8'h00, 1'b0));
        send_event(make_event(ACT_TX_READY, 8'hFF, 1'b1));
        for (int code = ACT_UNUSED_LO; code <= ACT_UNUSED_HI; code++) begin
            send_event(make_event(3'(code), 8'($urandom_range(0, 255)), 1'b1));
        end
    endtask

    // Every event with extreme bytes, ordering, error flag and flush.
    task automatic test_basic_events();
        send_event(make_event(ACT_HOST_WRITE, 8'h00, 1'b1));
        send_event(make_event(ACT_HOST_WRITE, 8'hFF, 1'b0));
        send_event(make_event(ACT_TX_READY, 8'h00, 1'b0));
        send_event(make_event(ACT_TX_READY, 8'h00, 1'b0));
        send_event(make_event(ACT_RX_BYTE, 8'h00, 1'b0));
        send_event(make_event(ACT_RX_BYTE, 8'hFF, 1'b1));
        send_event(make_event(ACT_HOST_READ, 8'h00, 1'b0));
        send_event(make_event(ACT_RX_BYTE, 8'hAA, 1'b0));
        send_event(make_event(ACT_HOST_READ, 8'h00, 1'b0));
        send_event(make_event(ACT_HOST_WRITE, 8'h55, 1'b0));
        send_event(make_event(ACT_RX_BYTE, 8'h12, 1'b1));
        send_event(make_event(ACT_FLUSH, 8'hFF, 1'b1));
        send_event(make_event(ACT_HOST_READ, 8'h00, 1'b0));
        send_event(make_event(ACT_TX_READY, 8'h00, 1'b0));
    endtask

    // Fill both FIFOs past full, then pop past empty.
    task automatic test_full_fifos();
        logic ovr;
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        for (int i = 0; i < TX_DEPTH + 2; i++) begin
            send_event(make_event(ACT_HOST_WRITE, 8'($urandom_range(0, 255)), 1'b0));
        end
        // The error flag must track the line on dropped bytes in both directions.
        for (int i = 0; i < RX_DEPTH + 2; i++) begin
            ovr = (i >= RX_DEPTH) ? (i == RX_DEPTH) : 1'($urandom_range(0, 1));
            send_event(make_event(ACT_RX_BYTE, 8'($urandom_range(0, 255)), ovr));
        end
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        for (int i = 0; i < RX_DEPTH + 2; i++) begin
            send_event(make_event(ACT_HOST_READ, 8'($urandom_range(0, 255)), 1'b0));
            send_event(make_event(ACT_TX_READY, 8'($urandom_range(0, 255)), 1'b0));
        end
    endtask

    // Bursts of random traffic, each with its own push bias and idle pattern.
    task automatic test_random_traffic();
        int bias [4] = '{20, 50, 80, 95};
        int push_pct;
        for (int burst = 0; burst < 5; burst++) begin
            push_pct = bias[$urandom_range(0, 3)];
            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < 50; i++) begin
                send_event(random_event(push_pct));
            end
            if (burst == 2) begin
                hold_until_drained();
            end
        end
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    // Test sequence.
    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_and_unused();
        test_basic_events();
        hold_until_drained();
        test_full_fifos();
        hold_until_drained();
        test_random_traffic();

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
